/* rtl/core/dpf_pkg.sv */
// Shared constants and types for the Doppler pitch factor pipeline.
// No dependencies; imported by dpf_dir and doppler_pitch_factor.
package dpf_pkg;

  localparam int unsigned SqrtBits  = 31;  // root bits of the squared offset length
  localparam int unsigned UnitBits  = 31;  // magnitude bits of one unit component, Q2.30
  localparam int unsigned RatioBits = 18;  // quotient bits of the Doppler ratio, Q2.16

  localparam logic [23:0]        PitchFloor = 24'd66;
  localparam logic signed [59:0] SoundQ32   = 60'sd1473173782528;  // 343 m/s in Q.32
  localparam logic signed [59:0] OneQ32     = 60'sd4294967296;
  localparam logic [31:0]        UnitQ30    = 32'h4000_0000;
  localparam logic [17:0]        RatioMin   = 18'd32768;
  localparam logic [17:0]        RatioMax   = 18'd131072;
  localparam logic [17:0]        RatioUnity = 18'd65536;
  localparam logic [24:0]        PitchMax   = 25'h1FF_FFFF;

  // Per-voice data that rides along with the direction computation
  typedef struct packed {
    logic [2:0][31:0] vl;
    logic [2:0][31:0] vs;
    logic [23:0]      pitch;
    logic [23:0]      scale;
  } side_t;

  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

endpackage

/* rtl/core/dpf_ifs.sv */
// Valid/ready channel interfaces for the Doppler pitch factor block.
// Standalone; no package dependency.
interface dpf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] offset_x;
  logic signed [31:0] offset_y;
  logic signed [31:0] offset_z;
  logic signed [31:0] listener_vel_x;
  logic signed [31:0] listener_vel_y;
  logic signed [31:0] listener_vel_z;
  logic signed [31:0] source_vel_x;
  logic signed [31:0] source_vel_y;
  logic signed [31:0] source_vel_z;
  logic        [23:0] base_pitch;
  logic        [23:0] doppler_scale;

  modport source (
    output valid, offset_x, offset_y, offset_z,
    output listener_vel_x, listener_vel_y, listener_vel_z,
    output source_vel_x, source_vel_y, source_vel_z,
    output base_pitch, doppler_scale,
    input  ready
  );
  modport sink (
    input  valid, offset_x, offset_y, offset_z,
    input  listener_vel_x, listener_vel_y, listener_vel_z,
    input  source_vel_x, source_vel_y, source_vel_z,
    input  base_pitch, doppler_scale,
    output ready
  );
endinterface

interface dpf_out_if;
  logic        valid;
  logic        ready;
  logic [24:0] effective_pitch;
  logic [17:0] doppler_factor;
  logic        doppler_applied;

  modport source (
    output valid, effective_pitch, doppler_factor, doppler_applied,
    input  ready
  );
  modport sink (
    input  valid, effective_pitch, doppler_factor, doppler_applied,
    output ready
  );
endinterface

/* rtl/core/dpf_dir.sv */
// Unit direction of the offset vector: normalize, length by pipelined square
// root, then one restoring divider per component. Depends on dpf_pkg.
module dpf_dir (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dpf_pkg::pipe_ctl_t ctl_i,
  input  logic [2:0][31:0]   offset_i,
  input  dpf_pkg::side_t     side_i,
  output logic               vld_o,
  output logic [2:0][31:0]   dir_o,
  output dpf_pkg::side_t     side_o
);
  import dpf_pkg::*;

  typedef struct packed {
    logic [30:0]      root;
    logic [61:0]      rem;
    logic [2:0][30:0] an;
    logic [2:0]       sgn;
    side_t            side;
  } root_t;

  typedef struct packed {
    logic [30:0]      len;
    logic [2:0][31:0] r;
    logic [2:0][30:0] q;
    logic [2:0]       sgn;
    side_t            side;
  } quo_t;

  // Normalize stage
  logic [2:0][31:0] mag_in;
  logic [31:0]      mag_max;
  logic [4:0]       up_shift;
  logic [2:0][31:0] norm_d, norm_q;
  logic             norm_vld_q;
  side_t            norm_side_q;

  always_comb begin
    mag_max  = '0;
    up_shift = '0;
    for (int k = 0; k < 3; k++) begin
      mag_in[k] = offset_i[k][31] ? (~offset_i[k] + 32'd1) : offset_i[k];
      if (mag_in[k] > mag_max) mag_max = mag_in[k];
    end
    for (int b = 0; b < 30; b++) begin
      if (mag_max[b]) up_shift = 5'(29 - b);
    end
    for (int k = 0; k < 3; k++) begin
      if (mag_max == '0) begin
        // zero offset: point along +z
        norm_d[k] = (k == 2) ? UnitQ30 : '0;
      end else if (mag_max > UnitQ30) begin
        norm_d[k] = 32'(($signed(offset_i[k]) + $signed({31'd0, offset_i[k][31]})) >>> 1);
      end else begin
        norm_d[k] = offset_i[k] << up_shift;
      end
    end
  end

  // Square stage
  logic [2:0][30:0] abs_d, abs_q;
  logic [2:0]       sgn_d, sgn_q;
  logic [2:0][61:0] sq_d, sq_q;
  logic             sq_vld_q;
  side_t            sq_side_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sgn_d[k] = norm_q[k][31];
      abs_d[k] = norm_q[k][31] ? 31'(~norm_q[k] + 32'd1) : norm_q[k][30:0];
      sq_d[k]  = abs_d[k] * abs_d[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_vld_q <= 1'b0;
      sq_vld_q   <= 1'b0;
    end else if (ctl_i.en) begin
      norm_vld_q <= ctl_i.vld;
      sq_vld_q   <= norm_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      norm_q      <= norm_d;
      norm_side_q <= side_i;
      abs_q       <= abs_d;
      sgn_q       <= sgn_d;
      sq_q        <= sq_d;
      sq_side_q   <= norm_side_q;
    end
  end

  // Square root, one result bit per stage
  root_t rt_q     [SqrtBits+1];
  logic  rt_vld_q [SqrtBits+1];
  root_t rt0_d;

  always_comb begin
    rt0_d.root = '0;
    rt0_d.rem  = sq_q[0] + sq_q[1] + sq_q[2];
    rt0_d.an   = abs_q;
    rt0_d.sgn  = sgn_q;
    rt0_d.side = sq_side_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rt_vld_q[0] <= 1'b0;
    else if (ctl_i.en) rt_vld_q[0] <= sq_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) rt_q[0] <= rt0_d;
  end

  for (genvar j = 0; j < SqrtBits; j++) begin : g_root
    localparam int unsigned Bit = SqrtBits - 1 - j;
    root_t       stage_d;
    logic [63:0] trial;

    always_comb begin
      stage_d = rt_q[j];
      trial   = ({33'd0, rt_q[j].root} << (Bit + 1)) + (64'd1 << (2 * Bit));
      if ({2'b00, rt_q[j].rem} >= trial) begin
        stage_d.rem       = rt_q[j].rem - trial[61:0];
        stage_d.root[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) rt_vld_q[j+1] <= 1'b0;
      else if (ctl_i.en) rt_vld_q[j+1] <= rt_vld_q[j];
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) rt_q[j+1] <= stage_d;
    end
  end

  // Component divide: |n| * 2^30 / len, one quotient bit per stage
  quo_t dv_q     [UnitBits+1];
  logic dv_vld_q [UnitBits+1];
  quo_t dv0_d;

  always_comb begin
    dv0_d.len  = rt_q[SqrtBits].root;
    dv0_d.q    = '0;
    dv0_d.sgn  = rt_q[SqrtBits].sgn;
    dv0_d.side = rt_q[SqrtBits].side;
    for (int k = 0; k < 3; k++) begin
      dv0_d.r[k] = {1'b0, rt_q[SqrtBits].an[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_vld_q[0] <= 1'b0;
    else if (ctl_i.en) dv_vld_q[0] <= rt_vld_q[SqrtBits];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) dv_q[0] <= dv0_d;
  end

  for (genvar j = 0; j < UnitBits; j++) begin : g_quo
    localparam int unsigned Bit = UnitBits - 1 - j;
    quo_t             stage_d;
    logic [2:0][31:0] trial;

    always_comb begin
      stage_d = dv_q[j];
      for (int k = 0; k < 3; k++) begin
        // top bit starts from the magnitude itself, later bits shift in zeros
        trial[k] = (Bit == UnitBits - 1) ? dv_q[j].r[k] : {dv_q[j].r[k][30:0], 1'b0};
        stage_d.r[k] = trial[k];
        if (trial[k] >= {1'b0, dv_q[j].len}) begin
          stage_d.r[k]      = trial[k] - {1'b0, dv_q[j].len};
          stage_d.q[k][Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_vld_q[j+1] <= 1'b0;
      else if (ctl_i.en) dv_vld_q[j+1] <= dv_vld_q[j];
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) dv_q[j+1] <= stage_d;
    end
  end

  always_comb begin
    vld_o  = dv_vld_q[UnitBits];
    side_o = dv_q[UnitBits].side;
    for (int k = 0; k < 3; k++) begin
      dir_o[k] = dv_q[UnitBits].sgn[k] ? (~{1'b0, dv_q[UnitBits].q[k]} + 32'd1)
                                       : {1'b0, dv_q[UnitBits].q[k]};
    end
  end

endmodule

/* rtl/core/doppler_pitch_factor.sv */
// Top level of the Doppler pitch factor pipeline.
// Depends on dpf_pkg, dpf_in_if/dpf_out_if and dpf_dir.
//
// Takes one voice request per clock while the output is taken, returning
// results in order; throughput is one voice per cycle. The latency is mostly
// set by the bit-per-stage square root (31 stages) and component divider
// (31 stages) of the direction unit and the 18-stage ratio divider. An untaken
// output holds the whole pipeline, and no request is accepted until it moves.
module doppler_pitch_factor (
  input  logic      clk_i,
  input  logic      rst_ni,
  dpf_in_if.sink    in_i,
  dpf_out_if.source out_o
);
  import dpf_pkg::*;

  typedef struct packed {
    logic        ok;
    logic        over;
    logic [57:0] r;
    logic [57:0] den;
    logic [17:0] nlo;
    logic [17:0] q;
    logic [23:0] pitch;
  } rq_t;

  function automatic logic signed [33:0] q30_trunc(input logic signed [63:0] acc);
    logic signed [63:0] adj;
    adj = acc + (acc[63] ? 64'sd1073741823 : 64'sd0);
    return $signed(adj[63:30]);
  endfunction

  logic out_vld_q;
  logic en;

  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  // Input side
  side_t            side_in;
  pipe_ctl_t        ctl;
  logic [2:0][31:0] offset_in;

  always_comb begin
    ctl.en        = en;
    ctl.vld       = in_i.valid;
    offset_in     = {in_i.offset_z, in_i.offset_y, in_i.offset_x};
    side_in.vl    = {in_i.listener_vel_z, in_i.listener_vel_y, in_i.listener_vel_x};
    side_in.vs    = {in_i.source_vel_z, in_i.source_vel_y, in_i.source_vel_x};
    side_in.pitch = (in_i.base_pitch < PitchFloor) ? PitchFloor : in_i.base_pitch;
    side_in.scale = in_i.doppler_scale;
  end

  logic             dir_vld;
  logic [2:0][31:0] dir_vec;
  side_t            dir_side;

  dpf_dir u_dir (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .offset_i (offset_in),
    .side_i   (side_in),
    .vld_o    (dir_vld),
    .dir_o    (dir_vec),
    .side_o   (dir_side)
  );

  // Projection, terms and shift stages
  logic signed [63:0] s1_pl_d [3];
  logic signed [63:0] s1_ps_d [3];
  logic signed [63:0] s1_pl_q [3];
  logic signed [63:0] s1_ps_q [3];
  logic signed [63:0] s2_accl_q, s2_accs_q;
  logic signed [33:0] s3_projl_q, s3_projs_q;
  logic signed [58:0] s4_ml_q, s4_ms_q;
  logic signed [59:0] s5_num_q, s5_den_q;
  side_t              s1_side_q, s2_side_q, s3_side_q, s4_side_q, s5_side_q;
  logic               s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q;

  logic [3:0]  s6_sh;
  logic        s6_ok_d, s6_ok_q;
  logic [45:0] s6_numsh_d, s6_numsh_q;
  logic [57:0] s6_densh_d, s6_densh_q;
  logic [23:0] s6_pitch_q;
  logic        s6_vld_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s1_pl_d[k] = $signed(dir_side.vl[k]) * $signed(dir_vec[k]);
      s1_ps_d[k] = $signed(dir_side.vs[k]) * $signed(dir_vec[k]);
    end
  end

  always_comb begin
    s6_sh = '0;
    for (int b = 46; b < 58; b++) begin
      if (s5_num_q[b]) s6_sh = 4'(b - 45);
    end
    // halve both terms together until the numerator drops below 2^46
    s6_numsh_d = 46'(s5_num_q[57:0] >> s6_sh);
    s6_densh_d = s5_den_q[57:0] >> s6_sh;
    s6_ok_d    = (s5_side_q.scale != '0) && (s5_num_q > OneQ32) && (s5_den_q > OneQ32);
  end

  // Ratio divider setup
  logic [62:0] n_full;
  logic        over_d;
  rq_t         rq0_d;

  always_comb begin
    n_full      = {1'b0, s6_numsh_q, 16'd0} + {6'd0, s6_densh_q[57:1]};
    over_d      = {13'd0, n_full} >= {s6_densh_q, 18'd0};
    rq0_d.ok    = s6_ok_q;
    rq0_d.over  = over_d;
    rq0_d.r     = {13'd0, n_full[62:18]};
    rq0_d.den   = s6_densh_q;
    rq0_d.nlo   = n_full[17:0];
    rq0_d.q     = '0;
    rq0_d.pitch = s6_pitch_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= dir_vld;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_pl_q    <= s1_pl_d;
      s1_ps_q    <= s1_ps_d;
      s1_side_q  <= dir_side;
      s2_accl_q  <= s1_pl_q[0] + s1_pl_q[1] + s1_pl_q[2];
      s2_accs_q  <= s1_ps_q[0] + s1_ps_q[1] + s1_ps_q[2];
      s2_side_q  <= s1_side_q;
      s3_projl_q <= q30_trunc(s2_accl_q);
      s3_projs_q <= q30_trunc(s2_accs_q);
      s3_side_q  <= s2_side_q;
      s4_ml_q    <= $signed({1'b0, s3_side_q.scale}) * s3_projl_q;
      s4_ms_q    <= $signed({1'b0, s3_side_q.scale}) * s3_projs_q;
      s4_side_q  <= s3_side_q;
      s5_num_q   <= SoundQ32 - s4_ml_q;
      s5_den_q   <= SoundQ32 - s4_ms_q;
      s5_side_q  <= s4_side_q;
      s6_ok_q    <= s6_ok_d;
      s6_numsh_q <= s6_numsh_d;
      s6_densh_q <= s6_densh_d;
      s6_pitch_q <= s5_side_q.pitch;
    end
  end

  // Ratio divider, one quotient bit per stage
  rq_t  rq_q     [RatioBits+1];
  logic rq_vld_q [RatioBits+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rq_vld_q[0] <= 1'b0;
    else if (en) rq_vld_q[0] <= s6_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) rq_q[0] <= rq0_d;
  end

  for (genvar j = 0; j < RatioBits; j++) begin : g_ratio
    localparam int unsigned Bit = RatioBits - 1 - j;
    rq_t         stage_d;
    logic [58:0] trial;

    always_comb begin
      stage_d = rq_q[j];
      trial   = {rq_q[j].r, rq_q[j].nlo[Bit]};
      stage_d.r = trial[57:0];
      if (trial >= {1'b0, rq_q[j].den}) begin
        stage_d.r      = 58'(trial - {1'b0, rq_q[j].den});
        stage_d.q[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) rq_vld_q[j+1] <= 1'b0;
      else if (en) rq_vld_q[j+1] <= rq_vld_q[j];
    end

    always_ff @(posedge clk_i) begin
      if (en) rq_q[j+1] <= stage_d;
    end
  end

  // Clamp, pitch multiply, round and saturate
  rq_t         rq_last;
  logic [17:0] s8_ratio_d, s8_ratio_q;
  logic        s8_app_q, s8_vld_q;
  logic [23:0] s8_pitch_q;
  logic [41:0] s9_pp_q;
  logic [17:0] s9_ratio_q;
  logic        s9_app_q, s9_vld_q;
  logic [23:0] s9_pitch_q;
  logic [41:0] rnd;
  logic [24:0] eff_d, eff_q;
  logic [17:0] fac_q;
  logic        app_q;

  always_comb begin
    rq_last = rq_q[RatioBits];
    if (!rq_last.ok) begin
      s8_ratio_d = RatioUnity;
    end else if (rq_last.over || (rq_last.q > RatioMax)) begin
      s8_ratio_d = RatioMax;
    end else if (rq_last.q < RatioMin) begin
      s8_ratio_d = RatioMin;
    end else begin
      s8_ratio_d = rq_last.q;
    end
  end

  always_comb begin
    rnd = s9_pp_q + 42'd32768;
    if (!s9_app_q) begin
      eff_d = {1'b0, s9_pitch_q};
    end else if (rnd[41]) begin
      eff_d = PitchMax;
    end else begin
      eff_d = rnd[40:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_vld_q  <= 1'b0;
      s9_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s8_vld_q  <= rq_vld_q[RatioBits];
      s9_vld_q  <= s8_vld_q;
      out_vld_q <= s9_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_ratio_q <= s8_ratio_d;
      s8_app_q   <= rq_last.ok;
      s8_pitch_q <= rq_last.pitch;
      s9_pp_q    <= s8_pitch_q * s8_ratio_q;
      s9_ratio_q <= s8_ratio_q;
      s9_app_q   <= s8_app_q;
      s9_pitch_q <= s8_pitch_q;
      eff_q      <= eff_d;
      fac_q      <= s9_ratio_q;
      app_q      <= s9_app_q;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.effective_pitch = eff_q;
  assign out_o.doppler_factor  = fac_q;
  assign out_o.doppler_applied = app_q;

endmodule
